/* rtl/core/i2cee_pkg.sv */
package i2cee_pkg;

  // Command codes carried by the operation field
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RANDOM  = 2'd2,
    OP_CURRENT = 2'd3
  } op_e;

  // Field and register widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DevSelW  = 7;
  localparam int unsigned WaitW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BitCntW  = 3;
  localparam int unsigned ByteIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDevSel    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWaitTicks = 1'b1;

  // Register reset values (device 0x50 gives control bytes 0xa0 / 0xa1)
  localparam logic [DevSelW-1:0] DevSelReset    = 7'd80;
  localparam logic [WaitW-1:0]   WaitTicksReset = 16'd1000;

  // Byte positions within a write-type transfer
  localparam logic [ByteIdxW-1:0] ByteCtrl = 2'd0;
  localparam logic [ByteIdxW-1:0] ByteAddr = 2'd1;
  localparam logic [ByteIdxW-1:0] ByteData = 2'd2;

endpackage

/* rtl/core/i2c_eeprom_master_sequencer.sv */
// A result word is registered and shows in the cycle after its input is taken.
// One input word per cycle unless in_stall_o is high; each word is one I2C line
// phase and the phase sequencer advances once per word through a single register stage.
// in_stall_o rises only while a result word waits and out_stall_i is high.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, clears all
// control state and loads device select 0x50 and a write wait of 1000 ticks.
module i2c_eeprom_master_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input word channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [i2cee_pkg::OpW-1:0]            operation_i,
  input  logic [i2cee_pkg::ByteW-1:0]          word_address_i,
  input  logic [i2cee_pkg::ByteW-1:0]          write_data_i,
  input  logic                                 sda_in_i,
  // result word channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 scl_o,
  output logic                                 sda_out_o,
  output logic                                 busy_res_o,
  output logic [i2cee_pkg::ByteW-1:0]          read_data_o,
  output logic                                 read_valid_o,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [i2cee_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [i2cee_pkg::CfgDataW-1:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_HI = 4'd1,
    PH_ST_LO = 4'd2,
    PH_TX_LO = 4'd3,
    PH_TX_HI = 4'd4,
    PH_AK_LO = 4'd5,
    PH_AK_HI = 4'd6,
    PH_RX_LO = 4'd7,
    PH_RX_HI = 4'd8,
    PH_NA_LO = 4'd9,
    PH_NA_HI = 4'd10,
    PH_SP_A  = 4'd11,
    PH_SP_B  = 4'd12,
    PH_SP_C  = 4'd13,
    PH_WAIT  = 4'd14
  } phase_e;

  // configuration registers
  logic [i2cee_pkg::DevSelW-1:0] dev_sel_q;
  logic [i2cee_pkg::WaitW-1:0]   wait_ticks_q;

  // sequencer state
  phase_e                          phase_q, phase_d;
  logic [i2cee_pkg::BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [i2cee_pkg::ByteIdxW-1:0]  byte_idx_q, byte_idx_d;
  logic [i2cee_pkg::ByteW-1:0]     tx_shift_q, tx_shift_d;
  logic [i2cee_pkg::ByteW-1:0]     rx_shift_q, rx_shift_d;
  i2cee_pkg::op_e                  pend_op_q, pend_op_d;
  logic [i2cee_pkg::ByteW-1:0]     addr_hold_q, addr_hold_d;
  logic [i2cee_pkg::ByteW-1:0]     data_hold_q, data_hold_d;
  logic [i2cee_pkg::WaitW-1:0]     wait_cnt_q, wait_cnt_d;
  logic [i2cee_pkg::ByteW-1:0]     read_hold_q, read_hold_d;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic                            scl_q, scl_d;
  logic                            sda_q, sda_d;
  logic                            busy_q, busy_d;
  logic [i2cee_pkg::ByteW-1:0]     rdata_q;
  logic                            rvalid_q, rvalid_d;

  logic                            in_acc;
  i2cee_pkg::op_e                  op_in;
  logic [i2cee_pkg::BitCntW-1:0]   bit_cnt_inc;

  // input side holds off only while a result word is stuck
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign op_in       = i2cee_pkg::op_e'(operation_i);
  assign bit_cnt_inc = bit_cnt_q + 3'd1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sel_q    <= i2cee_pkg::DevSelReset;
      wait_ticks_q <= i2cee_pkg::WaitTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        i2cee_pkg::CfgDevSel:    dev_sel_q    <= cfg_data_i[i2cee_pkg::DevSelW-1:0];
        i2cee_pkg::CfgWaitTicks: wait_ticks_q <= cfg_data_i[i2cee_pkg::WaitW-1:0];
        default: ;
      endcase
    end
  end

  // one line phase per word
  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    byte_idx_d  = byte_idx_q;
    tx_shift_d  = tx_shift_q;
    rx_shift_d  = rx_shift_q;
    pend_op_d   = pend_op_q;
    addr_hold_d = addr_hold_q;
    data_hold_d = data_hold_q;
    wait_cnt_d  = wait_cnt_q;
    read_hold_d = read_hold_q;
    scl_d       = 1'b1;
    sda_d       = 1'b1;
    busy_d      = 1'b1;
    rvalid_d    = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (op_in != i2cee_pkg::OP_NONE) begin
          // command latched; this word is already the first start phase
          pend_op_d   = op_in;
          addr_hold_d = word_address_i;
          data_hold_d = write_data_i;
          tx_shift_d  = {dev_sel_q, op_in == i2cee_pkg::OP_CURRENT};
          bit_cnt_d   = '0;
          byte_idx_d  = i2cee_pkg::ByteCtrl;
          phase_d     = PH_ST_LO;
        end else begin
          busy_d = 1'b0;
        end
      end
      PH_ST_HI: phase_d = PH_ST_LO;
      PH_ST_LO: begin
        sda_d   = 1'b0;
        phase_d = PH_TX_LO;
      end
      PH_TX_LO: begin
        scl_d   = 1'b0;
        sda_d   = tx_shift_q[i2cee_pkg::ByteW-1];
        phase_d = PH_TX_HI;
      end
      PH_TX_HI: begin
        sda_d      = tx_shift_q[i2cee_pkg::ByteW-1];
        tx_shift_d = {tx_shift_q[i2cee_pkg::ByteW-2:0], 1'b0};
        bit_cnt_d  = bit_cnt_inc;
        phase_d    = (bit_cnt_inc == '0) ? PH_AK_LO : PH_TX_LO;
      end
      PH_AK_LO: begin
        scl_d   = 1'b0;
        phase_d = PH_AK_HI;
      end
      PH_AK_HI: begin
        // ack level is not checked; pick the next byte or the stop
        if (pend_op_q == i2cee_pkg::OP_CURRENT) begin
          bit_cnt_d = '0;
          phase_d   = PH_RX_LO;
        end else if (byte_idx_q == i2cee_pkg::ByteCtrl) begin
          tx_shift_d = addr_hold_q;
          byte_idx_d = i2cee_pkg::ByteAddr;
          phase_d    = PH_TX_LO;
        end else if (byte_idx_q == i2cee_pkg::ByteAddr &&
                     pend_op_q == i2cee_pkg::OP_WRITE) begin
          tx_shift_d = data_hold_q;
          byte_idx_d = i2cee_pkg::ByteData;
          phase_d    = PH_TX_LO;
        end else begin
          phase_d = PH_SP_A;
        end
      end
      PH_RX_LO: begin
        scl_d   = 1'b0;
        phase_d = PH_RX_HI;
      end
      PH_RX_HI: begin
        rx_shift_d = {rx_shift_q[i2cee_pkg::ByteW-2:0], sda_in_i};
        bit_cnt_d  = bit_cnt_inc;
        phase_d    = (bit_cnt_inc == '0) ? PH_NA_LO : PH_RX_LO;
      end
      PH_NA_LO: begin
        scl_d   = 1'b0;
        phase_d = PH_NA_HI;
      end
      PH_NA_HI: phase_d = PH_SP_A;
      PH_SP_A: begin
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        phase_d = PH_SP_B;
      end
      PH_SP_B: begin
        sda_d   = 1'b0;
        phase_d = PH_SP_C;
      end
      PH_SP_C: begin
        if (pend_op_q == i2cee_pkg::OP_WRITE) begin
          wait_cnt_d = wait_ticks_q;
          phase_d    = (wait_ticks_q == '0) ? PH_IDLE : PH_WAIT;
        end else if (pend_op_q == i2cee_pkg::OP_RANDOM) begin
          // dummy write done, restart as a current read
          pend_op_d  = i2cee_pkg::OP_CURRENT;
          tx_shift_d = {dev_sel_q, 1'b1};
          bit_cnt_d  = '0;
          byte_idx_d = i2cee_pkg::ByteCtrl;
          phase_d    = PH_ST_HI;
        end else begin
          read_hold_d = rx_shift_q;
          rvalid_d    = 1'b1;
          phase_d     = PH_IDLE;
        end
      end
      PH_WAIT: begin
        wait_cnt_d = wait_cnt_q - 16'd1;
        if (wait_cnt_d == '0) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        busy_d  = 1'b0;
        phase_d = PH_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= '0;
      byte_idx_q  <= '0;
      tx_shift_q  <= '0;
      rx_shift_q  <= '0;
      pend_op_q   <= i2cee_pkg::OP_NONE;
      addr_hold_q <= '0;
      data_hold_q <= '0;
      wait_cnt_q  <= '0;
      read_hold_q <= '0;
      out_valid_q <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      busy_q      <= 1'b0;
      rdata_q     <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q     <= phase_d;
        bit_cnt_q   <= bit_cnt_d;
        byte_idx_q  <= byte_idx_d;
        tx_shift_q  <= tx_shift_d;
        rx_shift_q  <= rx_shift_d;
        pend_op_q   <= pend_op_d;
        addr_hold_q <= addr_hold_d;
        data_hold_q <= data_hold_d;
        wait_cnt_q  <= wait_cnt_d;
        read_hold_q <= read_hold_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        busy_q      <= busy_d;
        rdata_q     <= read_hold_d;
        rvalid_q    <= rvalid_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_o        = scl_q;
  assign sda_out_o    = sda_q;
  assign busy_res_o   = busy_q;
  assign read_data_o  = rdata_q;
  assign read_valid_o = rvalid_q;

`ifndef ASSERT_OFF
  // write wait never sits on an exhausted count
  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WAIT |-> wait_cnt_q != '0)
    else $error("write wait phase with zero count");

  // a completed read word is always a busy stop word with both lines high
  a_rvalid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> busy_res_o && scl_o && sda_out_o)
    else $error("read completion outside a busy stop phase");

  // clock is only driven low inside a transaction
  a_scl_low_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !scl_o |-> busy_res_o)
    else $error("scl low while not busy");

  // the input side is held only behind a pending result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");
`endif

endmodule
